[sv/ftrle_pkg.sv]
package ftrle_pkg;

  // Width of the run length counter; a run closes at the all-ones count.
  localparam int unsigned CountBits = 32;
  localparam logic [31:0] CountLimit = 32'((64'd1 << CountBits) - 64'd1);

  // Widths fixed by the word format.
  localparam int unsigned TolBits = 41;
  localparam int unsigned MagBits = 40;

  // Depth of the queue between the front and the back end.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw = $clog2(FifoDepth);

  // One run record as it leaves the block.
  typedef struct packed {
    logic [15:0] run_value;
    logic [31:0] run_length;
    logic        final_run;
    logic [31:0] total_elements;
    logic [31:0] total_runs;
  } ftrle_rec_t;

  // What one accepted weight leaves for the back end: up to two records.
  typedef struct packed {
    logic       has_brk;
    logic       has_fin;
    ftrle_rec_t brk_rec;
    ftrle_rec_t fin_rec;
  } ftrle_entry_t;

  // Exponent field all ones: infinity or NaN.
  function automatic logic fp16_special(logic [15:0] h);
    return &h[14:10];
  endfunction

  // Magnitude of a finite fp16 value in units of 2^-24.
  function automatic logic [MagBits-1:0] fp16_mag(logic [15:0] h);
    logic [4:0]         ex;
    logic [MagBits-1:0] m;
    ex = h[14:10];
    if (ex == 5'd0) begin
      m = {(MagBits - 10)'(0), h[9:0]};
    end else begin
      m = {(MagBits - 11)'(0), 1'b1, h[9:0]} << (ex - 5'd1);
    end
    return m;
  endfunction

endpackage

[sv/ftrle_front.sv]
module ftrle_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [40:0]             cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic [15:0]             weight_i,
  input  logic                    final_weight_i,
  input  logic                    full_i,
  output logic                    in_stall_o,
  output logic                    push_o,
  output ftrle_pkg::ftrle_entry_t entry_o
);
  import ftrle_pkg::*;

  logic [TolBits-1:0] tol_q;
  logic [15:0]        held_value_q, held_value_d;
  logic [MagBits-1:0] held_mag_q, held_mag_d;
  logic [31:0]        held_length_q, held_length_d;
  logic               have_run_q, have_run_d;
  logic [31:0]        runs_q, runs_d;
  logic [31:0]        elems_q, elems_d;

  logic               accept;
  logic [MagBits-1:0] w_mag;
  logic [TolBits-1:0] diff;
  logic               joins;
  logic               brk;
  logic [15:0]        new_value;
  logic [MagBits-1:0] new_mag;
  logic [31:0]        new_length;
  logic [31:0]        runs_brk;
  logic [31:0]        elems_inc;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // Tolerance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Exact difference between the weight and the run's first value.
  assign w_mag = fp16_mag(weight_i);
  always_comb begin
    if (weight_i[15] ^ held_value_q[15]) begin
      diff = {1'b0, w_mag} + {1'b0, held_mag_q};
    end else if (w_mag >= held_mag_q) begin
      diff = {1'b0, w_mag - held_mag_q};
    end else begin
      diff = {1'b0, held_mag_q - w_mag};
    end
  end

  assign joins = (weight_i == held_value_q) ||
                 ((tol_q != '0) && !fp16_special(weight_i) &&
                  !fp16_special(held_value_q) && (diff <= tol_q));

  // Classify the weight and update the open run.
  always_comb begin
    elems_inc  = elems_q + 32'd1;
    brk        = 1'b0;
    new_value  = held_value_q;
    new_mag    = held_mag_q;
    new_length = held_length_q + 32'd1;
    runs_brk   = runs_q;
    if (!have_run_q) begin
      new_value  = weight_i;
      new_mag    = w_mag;
      new_length = 32'd1;
    end else if (!(joins && (held_length_q < CountLimit))) begin
      brk        = 1'b1;
      runs_brk   = runs_q + 32'd1;
      new_value  = weight_i;
      new_mag    = w_mag;
      new_length = 32'd1;
    end

    entry_o.has_brk                = brk;
    entry_o.brk_rec.run_value      = held_value_q;
    entry_o.brk_rec.run_length     = held_length_q;
    entry_o.brk_rec.final_run      = 1'b0;
    entry_o.brk_rec.total_elements = '0;
    entry_o.brk_rec.total_runs     = '0;
    entry_o.has_fin                = final_weight_i;
    entry_o.fin_rec.run_value      = new_value;
    entry_o.fin_rec.run_length     = new_length;
    entry_o.fin_rec.final_run      = 1'b1;
    entry_o.fin_rec.total_elements = elems_inc;
    entry_o.fin_rec.total_runs     = runs_brk + 32'd1;

    push_o = accept && (brk || final_weight_i);

    held_value_d  = held_value_q;
    held_mag_d    = held_mag_q;
    held_length_d = held_length_q;
    have_run_d    = have_run_q;
    runs_d        = runs_q;
    elems_d       = elems_q;
    if (accept) begin
      if (final_weight_i) begin
        held_value_d  = '0;
        held_mag_d    = '0;
        held_length_d = '0;
        have_run_d    = 1'b0;
        runs_d        = '0;
        elems_d       = '0;
      end else begin
        held_value_d  = new_value;
        held_mag_d    = new_mag;
        held_length_d = new_length;
        have_run_d    = 1'b1;
        runs_d        = runs_brk;
        elems_d       = elems_inc;
      end
    end
  end

  // Run state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_value_q  <= '0;
      held_mag_q    <= '0;
      held_length_q <= '0;
      have_run_q    <= 1'b0;
      runs_q        <= '0;
      elems_q       <= '0;
    end else begin
      held_value_q  <= held_value_d;
      held_mag_q    <= held_mag_d;
      held_length_q <= held_length_d;
      have_run_q    <= have_run_d;
      runs_q        <= runs_d;
      elems_q       <= elems_d;
    end
  end

endmodule

[sv/ftrle_fifo.sv]
module ftrle_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  ftrle_pkg::ftrle_entry_t entry_i,
  input  logic                    pop_i,
  output logic                    full_o,
  output logic                    empty_o,
  output ftrle_pkg::ftrle_entry_t entry_o
);
  import ftrle_pkg::*;

  ftrle_entry_t          mem_q [FifoDepth];
  logic [FifoAw-1:0]     wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0]     rd_ptr_q, rd_ptr_d;
  logic [FifoAw:0]       count_q, count_d;

  assign full_o  = (count_q == (FifoAw + 1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Pointer and fill count update; the caller never pushes when full
  // nor pops when empty.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoAw'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoAw'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (FifoAw + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (FifoAw + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[sv/ftrle_back.sv]
module ftrle_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty_i,
  input  ftrle_pkg::ftrle_entry_t entry_i,
  output logic                    pop_o,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output ftrle_pkg::ftrle_rec_t   rec_o
);
  import ftrle_pkg::*;

  logic       out_valid_q, out_valid_d;
  ftrle_rec_t out_rec_q, out_rec_d;
  logic       pend_q, pend_d;
  ftrle_rec_t pend_rec_q, pend_rec_d;
  logic       load_ok;

  assign load_ok     = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign rec_o       = out_rec_q;

  // Move the next record into the output register: a pending final record
  // first, then the records of the next queued entry in order.
  always_comb begin
    out_valid_d = out_valid_q;
    out_rec_d   = out_rec_q;
    pend_d      = pend_q;
    pend_rec_d  = pend_rec_q;
    pop_o       = 1'b0;
    if (load_ok) begin
      if (pend_q) begin
        out_valid_d = 1'b1;
        out_rec_d   = pend_rec_q;
        pend_d      = 1'b0;
      end else if (!empty_i) begin
        pop_o       = 1'b1;
        out_valid_d = 1'b1;
        if (entry_i.has_brk) begin
          out_rec_d  = entry_i.brk_rec;
          pend_d     = entry_i.has_fin;
          pend_rec_d = entry_i.fin_rec;
        end else begin
          out_rec_d = entry_i.fin_rec;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // Record payload registers.
  always_ff @(posedge clk_i) begin
    out_rec_q  <= out_rec_d;
    pend_rec_q <= pend_rec_d;
  end

endmodule

[sv/fp16_tolerant_rle_encoder.sv]
// Run-length encoder for fp16 weights. One weight is taken per cycle while
// the internal queue has room; a weight joins the open run when its bits
// match the run's first value or, with a nonzero tolerance, when both are
// finite and their exact difference (in 2^-24 units) is within tolerance.
// Each closed run leaves as one record word; the final weight's run carries
// the tensor totals. The output sustains one record per cycle while
// out_stall_i is low, so a weight that both breaks a run and ends the
// tensor yields two records; the four-entry queue between the classifier
// and the output stage absorbs that and lets each side stall on its own.
// With the queue empty and no stalls, the record closed by an accepted
// weight goes through the queue storage and then the output register
// before it is valid. Write the tolerance only while the block is idle.
module fp16_tolerant_rle_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [40:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] weight_i,
  input  logic        final_weight_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] run_value_o,
  output logic [31:0] run_length_o,
  output logic        final_run_o,
  output logic [31:0] total_elements_o,
  output logic [31:0] total_runs_o
);
  import ftrle_pkg::*;

  logic         push;
  logic         pop;
  logic         full;
  logic         empty;
  ftrle_entry_t push_entry;
  ftrle_entry_t head_entry;
  ftrle_rec_t   rec;

  // Classifier and run state.
  ftrle_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .weight_i       (weight_i),
    .final_weight_i (final_weight_i),
    .full_i         (full),
    .in_stall_o     (in_stall_o),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  // Queue of pending record pairs.
  ftrle_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .entry_o (head_entry)
  );

  // Record serializer and output register.
  ftrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .rec_o       (rec)
  );

  assign run_value_o      = rec.run_value;
  assign run_length_o     = rec.run_length;
  assign final_run_o      = rec.final_run;
  assign total_elements_o = rec.total_elements;
  assign total_runs_o     = rec.total_runs;

endmodule
